// File: hw/rtl/eafs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eafs_pkg;

    localparam int ANIM_W     = 2;
    localparam int FRAME_W    = 3;
    localparam int IMAGE_W    = 3;
    localparam int DELTA_W    = 12;
    localparam int ELAPSED_W  = 13;
    localparam int TIMER_W    = 16;
    localparam int ALU_W      = 17;
    localparam int MS_W       = 8;
    localparam int BIAS_W     = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [ANIM_W-1:0] ANIM_IDLE  = 2'd0;
    localparam logic [ANIM_W-1:0] ANIM_BLINK = 2'd1;
    localparam logic [ANIM_W-1:0] ANIM_LEFT  = 2'd2;
    localparam logic [ANIM_W-1:0] ANIM_RIGHT = 2'd3;

    localparam logic [IMAGE_W-1:0] IMG_OPEN   = 3'd0;
    localparam logic [IMAGE_W-1:0] IMG_FOCUS  = 3'd1;
    localparam logic [IMAGE_W-1:0] IMG_HALF   = 3'd2;
    localparam logic [IMAGE_W-1:0] IMG_CLOSED = 3'd3;
    localparam logic [IMAGE_W-1:0] IMG_LEFT   = 3'd4;
    localparam logic [IMAGE_W-1:0] IMG_RIGHT  = 3'd5;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BLINK_ENABLE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_INTERVAL  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVEMENT_ENABLE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_BIAS = 8'd3;

    localparam logic signed [BIAS_W-1:0] GAZE_THRESHOLD   = 10'sd90;
    localparam logic signed [BIAS_W-1:0] BIAS_LIMIT       = 10'sd256;
    localparam logic [TIMER_W-1:0]       DEFAULT_INTERVAL = 16'd1000;

    typedef struct packed {
        logic [IMAGE_W-1:0] frame_image;
        logic [FRAME_W-1:0] frame_position;
        logic [ANIM_W-1:0]  current_animation;
    } result_t;

    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } alu_res_t;

    function automatic logic [MS_W-1:0] frame_ms_f(input logic [ANIM_W-1:0] anim);
        logic [MS_W-1:0] ms;
        case (anim)
            ANIM_IDLE:  ms = 8'd140;
            ANIM_BLINK: ms = 8'd45;
            default:    ms = 8'd120;
        endcase
        return ms;
    endfunction

    function automatic logic [FRAME_W-1:0] frame_count_f(input logic [ANIM_W-1:0] anim);
        logic [FRAME_W-1:0] cnt;
        case (anim)
            ANIM_BLINK: cnt = 3'd5;
            default:    cnt = 3'd2;
        endcase
        return cnt;
    endfunction

    function automatic logic loops_f(input logic [ANIM_W-1:0] anim);
        return anim != ANIM_BLINK;
    endfunction

    function automatic logic [IMAGE_W-1:0] frame_image_f(input logic [ANIM_W-1:0] anim,
                                                         input logic [FRAME_W-1:0] pos);
        logic [IMAGE_W-1:0] img;
        img = IMG_OPEN;
        case (anim)
            ANIM_IDLE: begin
                if (pos == 3'd1) img = IMG_FOCUS;
            end
            ANIM_BLINK: begin
                case (pos)
                    3'd1, 3'd3: img = IMG_HALF;
                    3'd2:       img = IMG_CLOSED;
                    default:    img = IMG_OPEN;
                endcase
            end
            ANIM_LEFT: begin
                if (pos == 3'd0) img = IMG_LEFT;
                else if (pos == 3'd1) img = IMG_FOCUS;
            end
            default: begin
                if (pos == 3'd0) img = IMG_RIGHT;
                else if (pos == 3'd1) img = IMG_FOCUS;
            end
        endcase
        return img;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/eye_animation_frame_sequencer_unit.sv
// Channel  Direction  Beat fields (low bit up)
// s_       in         tdata: tick_ms[11:0], animation_select[13:12]; tuser: opcode
// m_       out        tdata: frame_image[2:0], frame_position[5:3], current_animation[7:6]
// cfg_     in         cfg_index selects register, cfg_data holds value (always ready)
//
// A trigger beat is taken in the idle state and gives no result. A tick beat that starts an animation
// goes from the base step to the output step; any other tick runs the loop step for each frame it
// advances and once more (at most 37 frames, for a 4095 ms tick that runs out a blink and goes on over 120 ms frames):
// one compare-subtract unit steps the frame time once per cycle.
// s_tready is low while a tick is being worked; one finished result waits in the output
// register and the next beat is still accepted. A second result holds the sequencer in its
// output step until m_tready frees the register. Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module eye_animation_frame_sequencer_unit
    import eafs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // tick_ms[11:0], animation_select[13:12]
    input  wire logic                  s_tuser,   // opcode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // frame_image, frame_position, animation
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    res_ready;
    logic    res_valid;
    result_t res;

    assign res_ready = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    eafs_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .in_delta  (s_tdata[DELTA_W-1:0]),
        .in_sel    (s_tdata[DELTA_W+ANIM_W-1:DELTA_W]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    // hold the result until the beat is taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (res_valid) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (res_valid) out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.current_animation, out_reg.frame_position, out_reg.frame_image};

endmodule

`default_nettype wire

// File: hw/rtl/eafs_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module eafs_alu
    import eafs_pkg::*;
(
    input  wire logic [ALU_W-1:0] op_a,
    input  wire logic [ALU_W-1:0] op_b,
    output alu_res_t              res
);

    logic [ALU_W:0] wide_diff;

    // borrow out of the top bit means a < b
    assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
    assign res.ge    = ~wide_diff[ALU_W];
    assign res.diff  = wide_diff[ALU_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/eafs_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module eafs_seq
    import eafs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_opcode,
    input  wire logic [DELTA_W-1:0]    in_delta,
    input  wire logic [ANIM_W-1:0]     in_sel,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  res_ready,
    output logic                       res_valid,
    output result_t                    res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BASE = 2'd1;
    localparam logic [1:0] S_LOOP = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [ANIM_W-1:0]        playing_reg, playing_next;
    logic [ANIM_W-1:0]        baseline_reg, baseline_next;
    logic [FRAME_W-1:0]       counter_reg, counter_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [TIMER_W-1:0]       timer_reg, timer_next;
    logic                     pending_reg, pending_next;
    logic                     override_reg, override_next;
    logic                     blinking_reg, blinking_next;
    logic [DELTA_W-1:0]       delta_reg, delta_next;
    logic                     blink_en_reg, blink_en_next;
    logic [TIMER_W-1:0]       interval_reg, interval_next;
    logic                     move_en_reg, move_en_next;
    logic signed [BIAS_W-1:0] bias_reg, bias_next;

    logic [ALU_W-1:0]         alu_a, alu_b;
    alu_res_t                 alu_res;
    logic [ANIM_W-1:0]        want;
    logic                     started;
    logic [FRAME_W-1:0]       counter_inc;
    logic [FRAME_W-1:0]       shown_pos;
    logic [TIMER_W-1:0]       cfg_interval;
    logic signed [BIAS_W-1:0] cfg_bias;

    eafs_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu_res)
    );

    // the base step compares the blink timer, every loop step the frame time
    always_comb begin
        if (state_reg == S_BASE) begin
            alu_a = {1'b0, timer_reg} + {{(ALU_W-DELTA_W){1'b0}}, delta_reg};
            alu_b = {1'b0, interval_reg};
        end else begin
            alu_a = {{(ALU_W-ELAPSED_W){1'b0}}, elapsed_reg};
            alu_b = {{(ALU_W-MS_W){1'b0}}, frame_ms_f(playing_reg)};
        end
    end

    always_comb begin
        if (!move_en_reg) want = ANIM_IDLE;
        else if (bias_reg <= -GAZE_THRESHOLD) want = ANIM_LEFT;
        else if (bias_reg >= GAZE_THRESHOLD) want = ANIM_RIGHT;
        else want = ANIM_IDLE;
    end

    assign counter_inc  = counter_reg + 3'd1;
    assign shown_pos    = (counter_reg > 3'd4) ? 3'd0 : counter_reg;
    assign cfg_interval = (cfg_data == '0) ? DEFAULT_INTERVAL : cfg_data[TIMER_W-1:0];
    assign cfg_bias     = ($signed(cfg_data[BIAS_W-1:0]) > BIAS_LIMIT) ? BIAS_LIMIT :
                          ($signed(cfg_data[BIAS_W-1:0]) < -BIAS_LIMIT) ? -BIAS_LIMIT :
                          $signed(cfg_data[BIAS_W-1:0]);

    assign in_ready = (state_reg == S_IDLE);
    assign res.frame_image       = frame_image_f(playing_reg, shown_pos);
    assign res.frame_position    = shown_pos;
    assign res.current_animation = playing_reg;

    always_comb begin
        state_next    = state_reg;
        playing_next  = playing_reg;
        baseline_next = baseline_reg;
        counter_next  = counter_reg;
        elapsed_next  = elapsed_reg;
        timer_next    = timer_reg;
        pending_next  = pending_reg;
        override_next = override_reg;
        blinking_next = blinking_reg;
        delta_next    = delta_reg;
        blink_en_next = blink_en_reg;
        interval_next = interval_reg;
        move_en_next  = move_en_reg;
        bias_next     = bias_reg;
        started       = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_opcode == OP_TRIGGER) begin
                        playing_next  = in_sel;
                        counter_next  = '0;
                        elapsed_next  = '0;
                        override_next = !loops_f(in_sel);
                        blinking_next = (in_sel == ANIM_BLINK);
                        pending_next  = 1'b1;
                        if (loops_f(in_sel)) baseline_next = in_sel;
                        else timer_next = '0;
                    end else begin
                        delta_next = in_delta;
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE: begin
                started = pending_reg;
                if (want != baseline_reg) begin
                    baseline_next = want;
                    if (!override_reg && playing_reg == baseline_reg) begin
                        playing_next = want;
                        counter_next = '0;
                        elapsed_next = '0;
                        started      = 1'b1;
                    end
                end
                pending_next = 1'b0;
                if (blink_en_reg) begin
                    if (!blinking_reg && !override_reg) begin
                        if (alu_res.ge) begin
                            // auto blink fires
                            playing_next  = ANIM_BLINK;
                            counter_next  = '0;
                            elapsed_next  = '0;
                            override_next = 1'b1;
                            blinking_next = 1'b1;
                            timer_next    = '0;
                            started       = 1'b1;
                        end else begin
                            timer_next = alu_a[TIMER_W-1:0];
                        end
                    end else if (blinking_reg) begin
                        timer_next = '0;
                    end
                end
                if (started) begin
                    state_next = S_OUT;
                end else begin
                    elapsed_next = elapsed_reg + {{(ELAPSED_W-DELTA_W){1'b0}}, delta_reg};
                    state_next   = S_LOOP;
                end
            end
            S_LOOP: begin
                if (alu_res.ge) begin
                    elapsed_next = alu_res.diff[ELAPSED_W-1:0];
                    if (counter_inc >= frame_count_f(playing_reg)) begin
                        counter_next = '0;
                        if (!loops_f(playing_reg)) begin
                            // blink done: resume baseline, keep leftover time
                            override_next = 1'b0;
                            blinking_next = 1'b0;
                            playing_next  = baseline_reg;
                            pending_next  = 1'b1;
                        end
                    end else begin
                        counter_next = counter_inc;
                    end
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (res_ready) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_valid) begin
            case (cfg_index)
                REG_BLINK_ENABLE: begin
                    blink_en_next = cfg_data[0];
                    if (cfg_data[0]) begin
                        if (timer_reg > interval_reg) timer_next = interval_reg;
                    end else begin
                        timer_next    = '0;
                        blinking_next = 1'b0;
                    end
                end
                REG_BLINK_INTERVAL: begin
                    interval_next = cfg_interval;
                    if (timer_reg > cfg_interval) timer_next = cfg_interval;
                end
                REG_MOVEMENT_ENABLE: begin
                    move_en_next = cfg_data[0];
                    if (!cfg_data[0]) bias_next = '0;
                end
                REG_HORIZONTAL_BIAS: begin
                    bias_next = cfg_bias;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            playing_reg  <= ANIM_IDLE;
            baseline_reg <= ANIM_IDLE;
            counter_reg  <= '0;
            elapsed_reg  <= '0;
            timer_reg    <= '0;
            pending_reg  <= 1'b1;
            override_reg <= 1'b0;
            blinking_reg <= 1'b0;
            blink_en_reg <= 1'b0;
            interval_reg <= DEFAULT_INTERVAL;
            move_en_reg  <= 1'b0;
            bias_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            playing_reg  <= playing_next;
            baseline_reg <= baseline_next;
            counter_reg  <= counter_next;
            elapsed_reg  <= elapsed_next;
            timer_reg    <= timer_next;
            pending_reg  <= pending_next;
            override_reg <= override_next;
            blinking_reg <= blinking_next;
            blink_en_reg <= blink_en_next;
            interval_reg <= interval_next;
            move_en_reg  <= move_en_next;
            bias_reg     <= bias_next;
        end
        delta_reg <= delta_next;
    end

    a_counter_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> counter_reg < frame_count_f(playing_reg))
        else $error("frame counter beyond animation length");

    a_elapsed_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> elapsed_reg < {{(ELAPSED_W-MS_W){1'b0}}, frame_ms_f(playing_reg)})
        else $error("frame time left unconsumed after tick");

    a_override_is_blink: assert property (@(posedge aclk) disable iff (!aresetn)
        override_reg == (playing_reg == ANIM_BLINK))
        else $error("override flag out of step with playing animation");

    a_blinking_needs_override: assert property (@(posedge aclk) disable iff (!aresetn)
        blinking_reg |-> override_reg)
        else $error("blink in progress without override");

    a_baseline_loops: assert property (@(posedge aclk) disable iff (!aresetn)
        baseline_reg != ANIM_BLINK)
        else $error("one-shot animation taken as baseline");

endmodule

`default_nettype wire

// File: verif/tb_eye_animation_frame_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_eye_animation_frame_sequencer_unit;
    import eafs_pkg::*;

    // indexes past the register map; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'd255;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // tick_ms[11:0], animation_select[13:12]
    logic                  s_tuser   = 1'b0; // opcode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // frame_image, frame_position, animation
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // sequencer state as predicted
    logic [ANIM_W-1:0] seq_playing       = ANIM_IDLE;
    logic [ANIM_W-1:0] seq_baseline      = ANIM_IDLE;
    int unsigned       seq_frame         = 0;
    int unsigned       seq_elapsed       = 0;
    int unsigned       seq_blink_timer   = 0;
    bit                seq_start_pending = 1'b1;
    bit                seq_override      = 1'b0;
    bit                seq_blinking      = 1'b0;

    // register copies
    bit          reg_blink_on = 1'b0;
    int unsigned reg_interval = DEFAULT_INTERVAL;
    bit          reg_move_on  = 1'b0;
    int          reg_bias     = 0;

    result_t frames_due[$];
    int      fault_count     = 0;
    int      feed_gap_pct    = 0;
    int      frame_stall_pct = 0;

    eye_animation_frame_sequencer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned frame_span_ms(input logic [ANIM_W-1:0] anim);
        case (anim)
            ANIM_IDLE:  return 140;
            ANIM_BLINK: return 45;
            default:    return 120;
        endcase
    endfunction

    function automatic void launch_animation(input logic [ANIM_W-1:0] sel);
        seq_playing       = sel;
        seq_frame         = 0;
        seq_elapsed       = 0;
        seq_override      = (sel == ANIM_BLINK);
        seq_blinking      = (sel == ANIM_BLINK);
        seq_start_pending = 1'b1;
        if (sel == ANIM_BLINK) begin
            seq_blink_timer = 0;
        end else begin
            seq_baseline = sel;
        end
    endfunction

    task automatic predict_beat(input logic op, input logic [DELTA_W-1:0] delta,
                                input logic [ANIM_W-1:0] sel);
        logic [ANIM_W-1:0] gaze;
        bit                fresh;
        result_t           frame;
        if (op == OP_TRIGGER) begin
            launch_animation(sel);
        end else begin
            gaze = ANIM_IDLE;
            if (reg_move_on && reg_bias <= -int'(GAZE_THRESHOLD)) begin
                gaze = ANIM_LEFT;
            end else if (reg_move_on && reg_bias >= int'(GAZE_THRESHOLD)) begin
                gaze = ANIM_RIGHT;
            end
            if (gaze != seq_baseline) begin
                // restart only if the old baseline is what is on screen
                if (!seq_override && seq_playing == seq_baseline) begin
                    seq_playing       = gaze;
                    seq_frame         = 0;
                    seq_elapsed       = 0;
                    seq_start_pending = 1'b1;
                end
                seq_baseline = gaze;
            end

            fresh             = seq_start_pending;
            seq_start_pending = 1'b0;

            if (reg_blink_on) begin
                if (!seq_blinking && !seq_override) begin
                    if (seq_blink_timer + delta >= reg_interval) begin
                        launch_animation(ANIM_BLINK);
                        seq_blink_timer   = 0;
                        fresh             = 1'b1;
                        seq_start_pending = 1'b0;
                    end else begin
                        seq_blink_timer += delta;
                    end
                end else if (seq_blinking) begin
                    seq_blink_timer = 0;
                end
            end

            if (!fresh) begin
                seq_elapsed += delta;
                while (seq_elapsed >= frame_span_ms(seq_playing)) begin
                    seq_elapsed -= frame_span_ms(seq_playing);
                    seq_frame++;
                    if (seq_frame >= ((seq_playing == ANIM_BLINK) ? 5 : 2)) begin
                        seq_frame = 0;
                        // blink is one-shot: fall back to baseline, leftover keeps counting
                        if (seq_playing == ANIM_BLINK) begin
                            seq_override      = 1'b0;
                            seq_blinking      = 1'b0;
                            seq_playing       = seq_baseline;
                            seq_start_pending = 1'b1;
                        end
                    end
                end
            end

            case (seq_frame)
                0: begin
                    case (seq_playing)
                        ANIM_LEFT:  frame.frame_image = IMG_LEFT;
                        ANIM_RIGHT: frame.frame_image = IMG_RIGHT;
                        default:    frame.frame_image = IMG_OPEN;
                    endcase
                end
                1:       frame.frame_image = (seq_playing == ANIM_BLINK) ? IMG_HALF : IMG_FOCUS;
                2:       frame.frame_image = (seq_playing == ANIM_BLINK) ? IMG_CLOSED : IMG_OPEN;
                3:       frame.frame_image = (seq_playing == ANIM_BLINK) ? IMG_HALF : IMG_OPEN;
                default: frame.frame_image = IMG_OPEN;
            endcase
            frame.frame_position    = FRAME_W'(seq_frame);
            frame.current_animation = seq_playing;
            frames_due.push_back(frame);
        end
    endtask

    task automatic send_beat(input logic op, input logic [DELTA_W-1:0] delta,
                             input logic [ANIM_W-1:0] sel);
        if ($urandom_range(99) < feed_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < feed_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, sel, delta};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predict_beat(op, delta, sel);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        int bias;
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        // a trigger leaves no result behind; let it land first
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BLINK_ENABLE: begin
                reg_blink_on = data[0];
                if (reg_blink_on) begin
                    if (seq_blink_timer > reg_interval) seq_blink_timer = reg_interval;
                end else begin
                    seq_blink_timer = 0;
                    seq_blinking    = 1'b0;
                end
            end
            REG_BLINK_INTERVAL: begin
                reg_interval = (data == 0) ? DEFAULT_INTERVAL : data;
                if (seq_blink_timer > reg_interval) seq_blink_timer = reg_interval;
            end
            REG_MOVEMENT_ENABLE: begin
                reg_move_on = data[0];
                if (!reg_move_on) reg_bias = 0;
            end
            REG_HORIZONTAL_BIAS: begin
                bias = int'($signed(data[BIAS_W-1:0]));
                if (bias > int'(BIAS_LIMIT)) bias = int'(BIAS_LIMIT);
                if (bias < -int'(BIAS_LIMIT)) bias = -int'(BIAS_LIMIT);
                reg_bias = bias;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : frame_checker
        result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (frames_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("ERROR: frame beat 0x%02h with none expected", m_tdata);
            end else begin
                due = frames_due.pop_front();
                if (m_tdata[2:0] != due.frame_image || m_tdata[5:3] != due.frame_position ||
                    m_tdata[7:6] != due.current_animation) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("ERROR: image %0d/%0d position %0d/%0d anim %0d/%0d (exp/act)",
                                 due.frame_image, m_tdata[2:0], due.frame_position,
                                 m_tdata[5:3], due.current_animation, m_tdata[7:6]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= frame_stall_pct);
    end

    // start ticks, frame boundaries, huge deltas
    task automatic test_power_on_ticks();
        send_beat(OP_TICK, 12'd4095, ANIM_RIGHT);
        send_beat(OP_TICK, 12'd139, ANIM_IDLE);
        send_beat(OP_TICK, 12'd1, ANIM_IDLE);
        send_beat(OP_TICK, 12'd0, ANIM_IDLE);
        send_beat(OP_TICK, 12'd4095, ANIM_IDLE);
    endtask

    // every trigger target, then a blink run to its end
    task automatic test_triggers();
        send_beat(OP_TRIGGER, 12'd4095, ANIM_LEFT);
        send_beat(OP_TICK, 12'd120, ANIM_IDLE);
        send_beat(OP_TRIGGER, 12'd0, ANIM_RIGHT);
        send_beat(OP_TICK, 12'd2000, ANIM_IDLE);
        send_beat(OP_TRIGGER, 12'hAAA, ANIM_IDLE);
        send_beat(OP_TRIGGER, 12'h555, ANIM_BLINK);
        send_beat(OP_TICK, 12'd44, ANIM_IDLE);
        send_beat(OP_TICK, 12'd45, ANIM_IDLE);
        send_beat(OP_TICK, 12'd160, ANIM_IDLE);
        send_beat(OP_TICK, 12'd30, ANIM_IDLE);
        send_beat(OP_TRIGGER, 12'd7, ANIM_BLINK);
        send_beat(OP_TICK, 12'd4095, ANIM_IDLE);
    endtask

    // bias clamp and gaze thresholds, interval extremes, auto blink, spare indexes
    task automatic test_register_extremes();
        write_register(REG_MOVEMENT_ENABLE, 16'hFFFF);
        write_register(REG_HORIZONTAL_BIAS, 16'hFDFF);
        send_beat(OP_TICK, 12'd10, ANIM_IDLE);
        write_register(REG_HORIZONTAL_BIAS, 16'h0A00);
        send_beat(OP_TICK, 12'd10, ANIM_IDLE);
        write_register(REG_HORIZONTAL_BIAS, 16'h03A6);
        write_register(REG_HORIZONTAL_BIAS, 16'hC3A7);
        send_beat(OP_TICK, 12'd10, ANIM_IDLE);
        write_register(REG_HORIZONTAL_BIAS, 16'h0059);
        write_register(REG_HORIZONTAL_BIAS, 16'h005A);
        send_beat(OP_TICK, 12'd10, ANIM_IDLE);
        write_register(REG_MOVEMENT_ENABLE, 16'hFFFE);
        send_beat(OP_TICK, 12'd10, ANIM_IDLE);
        write_register(REG_BLINK_INTERVAL, 16'h0000);
        write_register(REG_BLINK_INTERVAL, 16'h0001);
        write_register(REG_BLINK_ENABLE, 16'h0001);
        send_beat(OP_TICK, 12'd0, ANIM_IDLE);
        send_beat(OP_TICK, 12'd45, ANIM_IDLE);
        write_register(REG_BLINK_INTERVAL, 16'hFFFF);
        write_register(REG_SPARE_FIRST, 16'hFFFF);
        write_register(REG_SPARE_LAST, 16'h0000);
        write_register(REG_BLINK_ENABLE, 16'hFFFE);
        send_beat(OP_TICK, 12'd300, ANIM_IDLE);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int beats);
        int                    sent;
        int                    burst;
        logic                  op;
        logic [DELTA_W-1:0]    delta;
        logic [CFG_DATA_W-1:0] data;
        sent = 0;
        while (sent < beats) begin
            // reprogram between bursts, block drained
            repeat ($urandom_range(1, 4)) begin
                data = CFG_DATA_W'($urandom);
                case ($urandom_range(9))
                    0, 1: write_register(REG_BLINK_ENABLE, data);
                    2, 3: begin
                        case ($urandom_range(7))
                            0: data = 16'd0;
                            1: data = 16'd1;
                            2: data = 16'd45;
                            3: data = 16'hFFFF;
                            4, 5: data = CFG_DATA_W'($urandom_range(50, 3000));
                            default: ;
                        endcase
                        write_register(REG_BLINK_INTERVAL, data);
                    end
                    4, 5: begin
                        data[0] = ($urandom_range(9) < 7);
                        write_register(REG_MOVEMENT_ENABLE, data);
                    end
                    6, 7, 8: begin
                        case ($urandom_range(7))
                            0: data[BIAS_W-1:0] = BIAS_W'(-256);
                            1: data[BIAS_W-1:0] = BIAS_W'(256);
                            2: data[BIAS_W-1:0] = BIAS_W'(-90);
                            3: data[BIAS_W-1:0] = BIAS_W'(-89);
                            4: data[BIAS_W-1:0] = BIAS_W'(89);
                            5: data[BIAS_W-1:0] = BIAS_W'(90);
                            default: ;
                        endcase
                        write_register(REG_HORIZONTAL_BIAS, data);
                    end
                    default: write_register(CFG_IDX_W'($urandom_range(4, 255)), data);
                endcase
            end

            // some bursts run with no idling at all
            if ($urandom_range(4) == 0) begin
                feed_gap_pct    = 0;
                frame_stall_pct = 0;
            end else begin
                feed_gap_pct    = gap_pct;
                frame_stall_pct = stall_pct;
            end

            burst = $urandom_range(25, 55);
            if (burst > beats - sent) burst = beats - sent;
            repeat (burst) begin
                op = ($urandom_range(99) < 15) ? OP_TRIGGER : OP_TICK;
                case ($urandom_range(19))
                    0:             delta = $urandom_range(1) ? 12'hFFF : 12'h000;
                    1, 2:          delta = DELTA_W'($urandom);
                    3, 4, 5, 6, 7: delta = DELTA_W'($urandom_range(1000));
                    default:       delta = DELTA_W'($urandom_range(150));
                endcase
                send_beat(op, delta, ANIM_W'($urandom_range(3)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_on_ticks();
        test_triggers();
        test_register_extremes();
        test_random_traffic(0, 0, 235);
        test_random_traffic(61, 0, 235);
        test_random_traffic(0, 61, 235);
        test_random_traffic(30, 30, 235);

        s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
